[rtl/bcw_pkg.sv]
// Shared types and constants of the child blend weight evaluator.
// Used by bcw_div, bcw_child_mem and blend_child_weights; depends on nothing.
package bcw_pkg;

   localparam int IDX_W       = 4;
   localparam int CNT_W       = 5;
   localparam int MAX_RESULTS = 16;
   localparam int COORD_W     = 16;
   localparam int WGT_W       = 17;
   localparam int DIFF_W      = 17;
   localparam int PROD_W      = 34;
   localparam int DOT_W       = 36;
   localparam int BAND_W      = 52;
   localparam int WQ_W        = 51;
   localparam int TOT_W       = 55;
   localparam int NUM_W       = WQ_W + 16;
   localparam int DEN_W       = TOT_W;

   localparam logic [WGT_W-1:0] ONE_Q16 = 17'd65536;

   localparam logic [1:0] OP_GEO  = 2'd0;
   localparam logic [1:0] OP_DIR  = 2'd1;
   localparam logic [1:0] OP_EVAL = 2'd2;

   localparam logic [1:0] MODE_1D     = 2'd0;
   localparam logic [1:0] MODE_2D     = 2'd1;
   localparam logic [1:0] MODE_DIRECT = 2'd2;
   localparam logic [1:0] MODE_TWO    = 2'd3;

   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_COUNT = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] thr;
      logic [COORD_W-1:0] dir;
   } child_entry_type;

   typedef struct packed {
      logic               geo_en;
      logic               dir_en;
      logic [IDX_W-1:0]   idx;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] thr;
      logic [COORD_W-1:0] dir;
   } mem_wr_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [NUM_W-1:0] quo;
   } div_rsp_type;

endpackage

[rtl/bcw_div.sv]
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on bcw_pkg for widths and the request and response structs.
module bcw_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bcw_pkg::div_req_type div_req,
   output bcw_pkg::div_rsp_type div_rsp
);
   localparam int NW     = bcw_pkg::NUM_W;
   localparam int DW     = bcw_pkg::DEN_W;
   localparam int STEP_W = $clog2(NW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [NW-1:0]     quo_ff, quo_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [DW:0]       rem_sh;
   logic [DW+1:0]     diff;
   logic              fit;

   assign rem_sh = {rem_ff, quo_ff[NW-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};
   assign fit    = !diff[DW+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.num;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         rem_in = fit ? diff[DW-1:0] : rem_sh[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

[rtl/bcw_child_mem.sv]
// Child table memory: position, threshold and direct weight per child.
// One write port with two lanes, one registered read port; uses bcw_pkg.
module bcw_child_mem #(
   parameter int MAX_CHILDREN = 16
) (
   input  logic                                 clock,
   input  bcw_pkg::mem_wr_type                  wr,
   input  logic [bcw_pkg::IDX_W-1:0]            rd_idx,
   output bcw_pkg::child_entry_type             rd_q
);
   localparam int AW = $clog2(MAX_CHILDREN);
   localparam int EW = AW + bcw_pkg::IDX_W;

   bcw_pkg::child_entry_type mem [MAX_CHILDREN];
   bcw_pkg::child_entry_type q_ff;

   logic [EW-1:0] wr_ext, rd_ext;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_ok;

   assign wr_ext  = {{AW{1'b0}}, wr.idx};
   assign rd_ext  = {{AW{1'b0}}, rd_idx};
   assign wr_addr = wr_ext[AW-1:0];
   assign rd_addr = rd_ext[AW-1:0];
   assign wr_ok   = wr_ext < EW'(MAX_CHILDREN);

   always_ff @(posedge clock) begin
      if (wr.geo_en && wr_ok) begin
         mem[wr_addr].x   <= wr.x;
         mem[wr_addr].y   <= wr.y;
         mem[wr_addr].thr <= wr.thr;
      end
      if (wr.dir_en && wr_ok) begin
         mem[wr_addr].dir <= wr.dir;
      end
      q_ff <= mem[rd_addr];
   end

   assign rd_q = q_ff;

endmodule

[rtl/blend_child_weights.sv]
// Child blend weight evaluator: sequencer, shared 17x17 multiplier, shared serial divider.
// One evaluation runs at a time.
// Synchronous reset clears mode, child count and control; the tables are not cleared.
// Depends on bcw_pkg, bcw_div and bcw_child_mem.
module blend_child_weights #(
   parameter int MAX_CHILDREN = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_child_index,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic signed [15:0] req_threshold_value,
   input  logic signed [15:0] req_direct_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_weight_index,
   output logic [16:0] rsp_weight,
   output logic        rsp_last,
   output logic        rsp_no_children,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);
   localparam int IW = bcw_pkg::IDX_W;
   localparam int CW = bcw_pkg::CNT_W;
   localparam int DOT_W = bcw_pkg::DOT_W;
   localparam int BAND_W = bcw_pkg::BAND_W;
   localparam int WQ_W = bcw_pkg::WQ_W;
   localparam int TOT_W = bcw_pkg::TOT_W;
   localparam int NUM_W = bcw_pkg::NUM_W;
   localparam int DEN_W = bcw_pkg::DEN_W;
   localparam int WG = bcw_pkg::WGT_W;
   localparam int LIM = (MAX_CHILDREN < bcw_pkg::MAX_RESULTS) ? MAX_CHILDREN
                                                              : bcw_pkg::MAX_RESULTS;

   localparam logic [4:0] S_IDLE  = 5'd0,  S_START = 5'd1,  S_SEL   = 5'd2,
                          S_EMIT  = 5'd3,  S_DWAIT = 5'd4,  S1_RD   = 5'd5,
                          S1_LD   = 5'd6,  S1_DEC  = 5'd7,  S1_DIVD = 5'd8,
                          S2_RDI  = 5'd9,  S2_LDI  = 5'd10, S2_RDJ  = 5'd11,
                          S2_LDJ  = 5'd12, S2_MUL  = 5'd13, S2_DIV  = 5'd14,
                          S2_UPD  = 5'd15, S2_FIN  = 5'd16, S2_CHK  = 5'd17,
                          SN_RD   = 5'd18, SN_LD   = 5'd19, SN_MUL  = 5'd20,
                          SN_CMP  = 5'd21, SD_RD   = 5'd22, SD_LD   = 5'd23,
                          NR_RD   = 5'd24, NR_LD   = 5'd25, NR_DIVD = 5'd26;

   logic [4:0]  state_ff, state_in, ret_ff, ret_in;
   logic [1:0]  mode_ff, mode_in;
   logic [CW-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in;
   logic [2:0]  ph_ff, ph_in;
   logic        hv_ff, hv_in, sbv_ff, sbv_in, nc_ff, nc_in;
   logic        lov_ff, lov_in, hiv_ff, hiv_in, dz_ff, dz_in, neg_ff, neg_in;
   logic        rv_ff, rv_in;
   logic signed [15:0] px_ff, px_in, py_ff, py_in, xi_ff, xi_in, yi_ff, yi_in;
   logic signed [15:0] mn_ff, mn_in, mx_ff, mx_in, lo_ff, lo_in, hi1_ff, hi1_in;
   logic [IW-1:0] mni_ff, mni_in, mxi_ff, mxi_in, loi_ff, loi_in, hii_ff, hii_in;
   logic [IW-1:0] sa_ff, sa_in, sb_ff, sb_in, bi_ff, bi_in;
   logic [WG-1:0] wa_ff, wa_in, wb_ff, wb_in, res_ff, res_in;
   logic signed [16:0] ipx_ff, ipx_in, ipy_ff, ipy_in, ijx_ff, ijx_in, ijy_ff, ijy_in;
   logic signed [bcw_pkg::PROD_W-1:0] prod_ff, prod_in, prod;
   logic signed [DOT_W-1:0] den_ff, den_in, num_ff, num_in, bd_ff, bd_in;
   logic signed [BAND_W-1:0] hi_ff, hi_in;
   logic [TOT_W-1:0] tot_ff, tot_in;
   logic [IW-1:0] o_idx_ff, o_idx_in;
   logic [WG-1:0] o_w_ff, o_w_in;
   logic        o_last_ff, o_last_in, o_nc_ff, o_nc_in;

   logic [CW-1:0] n_w;
   logic signed [16:0] mul_a, mul_b;
   logic        out_free;
   logic [WQ_W-1:0] w_mem [bcw_pkg::MAX_RESULTS];
   logic [WQ_W-1:0] w_rd;
   logic [WQ_W-1:0] w_fin, w_dir, w_src;
   logic signed [BAND_W-1:0] qs, band_val;
   logic [DOT_W-1:0] mag;
   logic signed [15:0] ent_x, ent_y, ent_t, ent_d;
   logic signed [16:0] d17a, d17b;
   logic [8:0]  p2;
   logic        accept;

   bcw_pkg::mem_wr_type      mem_wr;
   bcw_pkg::child_entry_type mem_q;
   bcw_pkg::div_req_type     div_req;
   bcw_pkg::div_rsp_type     div_rsp;
   logic [IW-1:0]            rd_idx;

   bcw_child_mem #(.MAX_CHILDREN(MAX_CHILDREN)) u_mem (
      .clock (clock),
      .wr    (mem_wr),
      .rd_idx(rd_idx),
      .rd_q  (mem_q)
   );

   bcw_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign n_w       = (cnt_ff > CW'(LIM)) ? CW'(LIM) : cnt_ff;
   assign out_free  = !rv_ff || !rsp_stall;
   assign rd_idx    = (state_ff == S2_RDJ) ? j_ff[IW-1:0] : i_ff[IW-1:0];

   assign mem_wr.geo_en = accept && (req_opcode == bcw_pkg::OP_GEO);
   assign mem_wr.dir_en = accept && (req_opcode == bcw_pkg::OP_DIR);
   assign mem_wr.idx    = req_child_index;
   assign mem_wr.x      = req_coord_x;
   assign mem_wr.y      = req_coord_y;
   assign mem_wr.thr    = req_threshold_value;
   assign mem_wr.dir    = req_direct_value;

   assign ent_x = $signed(mem_q.x);
   assign ent_y = $signed(mem_q.y);
   assign ent_t = $signed(mem_q.thr);
   assign ent_d = $signed(mem_q.dir);

   // Shared multiplier operands follow the product phase.
   always_comb begin
      mul_a = ipx_ff;
      mul_b = ipx_ff;
      if (state_ff == S2_MUL) begin
         case (ph_ff)
            3'd0:    begin mul_a = ijx_ff; mul_b = ijx_ff; end
            3'd1:    begin mul_a = ijy_ff; mul_b = ijy_ff; end
            3'd2:    begin mul_a = ipx_ff; mul_b = ijx_ff; end
            default: begin mul_a = ipy_ff; mul_b = ijy_ff; end
         endcase
      end else if (ph_ff != 3'd0) begin
         mul_a = ipy_ff;
         mul_b = ipy_ff;
      end
   end
   assign prod = mul_a * mul_b;

   assign mag      = neg_ff ? DOT_W'(-num_ff) : DOT_W'(num_ff);
   assign qs       = neg_ff ? -$signed({1'b0, div_rsp.quo[BAND_W-2:0]})
                            :  $signed({1'b0, div_rsp.quo[BAND_W-2:0]});
   assign band_val = dz_ff ? $signed({{(BAND_W-WG){1'b0}}, bcw_pkg::ONE_Q16})
                           : $signed({{(BAND_W-WG){1'b0}}, bcw_pkg::ONE_Q16}) - qs;
   assign w_fin    = hi_ff[BAND_W-1] ? '0 : hi_ff[WQ_W-1:0];
   assign w_dir    = {{(WQ_W-16){1'b0}}, ent_d[15] ? 16'd0 : mem_q.dir};
   assign w_src    = (mode_ff == bcw_pkg::MODE_2D) ? w_rd : w_dir;
   assign d17a     = {px_ff[15], px_ff} - {lo_ff[15], lo_ff};
   assign d17b     = {hi1_ff[15], hi1_ff} - {lo_ff[15], lo_ff};
   assign p2       = px_ff[15] ? 9'd0 : ((px_ff > 16'sd256) ? 9'd256 : px_ff[8:0]);

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;    mode_in = mode_ff;  cnt_in = cnt_ff;
      i_in = i_ff;          j_in = j_ff;        ph_in = ph_ff;      hv_in = hv_ff;
      sbv_in = sbv_ff;      nc_in = nc_ff;      lov_in = lov_ff;    hiv_in = hiv_ff;
      dz_in = dz_ff;        neg_in = neg_ff;    px_in = px_ff;      py_in = py_ff;
      xi_in = xi_ff;        yi_in = yi_ff;      mn_in = mn_ff;      mx_in = mx_ff;
      lo_in = lo_ff;        hi1_in = hi1_ff;    mni_in = mni_ff;    mxi_in = mxi_ff;
      loi_in = loi_ff;      hii_in = hii_ff;    sa_in = sa_ff;      sb_in = sb_ff;
      bi_in = bi_ff;        wa_in = wa_ff;      wb_in = wb_ff;      res_in = res_ff;
      ipx_in = ipx_ff;      ipy_in = ipy_ff;    ijx_in = ijx_ff;    ijy_in = ijy_ff;
      prod_in = prod_ff;    den_in = den_ff;    num_in = num_ff;    bd_in = bd_ff;
      hi_in = hi_ff;        tot_in = tot_ff;
      o_idx_in = o_idx_ff;  o_w_in = o_w_ff;    o_last_in = o_last_ff; o_nc_in = o_nc_ff;
      rv_in = rv_ff;
      div_req.start = 1'b0;
      div_req.num   = {{(NUM_W-DOT_W-16){1'b0}}, mag, 16'd0};
      div_req.den   = {{(DEN_W-DOT_W){1'b0}}, den_ff};

      if (csr_valid && csr_ready) begin
         if (csr_index == bcw_pkg::REG_MODE) mode_in = csr_wdata[1:0];
         else cnt_in = csr_wdata;
      end
      if (rv_ff && !rsp_stall) rv_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_opcode == bcw_pkg::OP_EVAL)) begin
               px_in = req_coord_x;
               py_in = req_coord_y;
               state_in = S_START;
            end
         end
         S_START: begin
            i_in = '0; j_in = '0; hv_in = 1'b0; lov_in = 1'b0; hiv_in = 1'b0;
            tot_in = '0; nc_in = 1'b0; sbv_in = 1'b0; sa_in = '0; sb_in = 4'd1;
            wa_in = bcw_pkg::ONE_Q16; ph_in = '0;
            if (n_w == '0) begin
               nc_in = 1'b1;
               res_in = '0;
               ret_in = S_IDLE;
               state_in = S_EMIT;
            end else begin
               case (mode_ff)
                  bcw_pkg::MODE_1D: state_in = (n_w == CW'(1)) ? S_SEL : S1_RD;
                  bcw_pkg::MODE_2D: state_in = (n_w == CW'(1)) ? S_SEL : S2_RDI;
                  bcw_pkg::MODE_DIRECT: state_in = SD_RD;
                  default: begin
                     wb_in = {p2, 8'd0};
                     wa_in = bcw_pkg::ONE_Q16 - {p2, 8'd0};
                     sbv_in = 1'b1;
                     state_in = S_SEL;
                  end
               endcase
            end
         end
         S_SEL: begin
            if (i_ff[IW-1:0] == sa_ff) res_in = wa_ff;
            else if (sbv_ff && (i_ff[IW-1:0] == sb_ff)) res_in = wb_ff;
            else res_in = '0;
            ret_in = S_SEL;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rv_in = 1'b1;
               o_idx_in = i_ff[IW-1:0];
               o_w_in = res_ff;
               o_nc_in = nc_ff;
               o_last_in = nc_ff || ((i_ff + 1'b1) == n_w);
               if (nc_ff || ((i_ff + 1'b1) >= n_w)) begin
                  state_in = S_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = ret_ff;
               end
            end
         end
         S_DWAIT: begin
            if (div_rsp.done) state_in = ret_ff;
         end
         S1_RD: state_in = S1_LD;
         S1_LD: begin
            if (i_ff == '0 || ent_t < mn_ff) begin
               mn_in = ent_t; mni_in = i_ff[IW-1:0];
            end
            if (i_ff == '0 || ent_t >= mx_ff) begin
               mx_in = ent_t; mxi_in = i_ff[IW-1:0];
            end
            // Bracket: largest threshold below p (latest on ties), smallest at or above p.
            if (ent_t < px_ff && (!lov_ff || ent_t >= lo_ff)) begin
               lo_in = ent_t; loi_in = i_ff[IW-1:0]; lov_in = 1'b1;
            end
            if (ent_t >= px_ff && (!hiv_ff || ent_t < hi1_ff)) begin
               hi1_in = ent_t; hii_in = i_ff[IW-1:0]; hiv_in = 1'b1;
            end
            i_in = i_ff + 1'b1;
            state_in = ((i_ff + 1'b1) < n_w) ? S1_RD : S1_DEC;
         end
         S1_DEC: begin
            i_in = '0;
            if (px_ff <= mn_ff) begin
               sa_in = mni_ff; state_in = S_SEL;
            end else if (px_ff >= mx_ff) begin
               sa_in = mxi_ff; state_in = S_SEL;
            end else begin
               div_req.start = 1'b1;
               div_req.num = {{(NUM_W-33){1'b0}}, d17a, 16'd0};
               div_req.den = {{(DEN_W-17){1'b0}}, d17b};
               ret_in = S1_DIVD;
               state_in = S_DWAIT;
            end
         end
         S1_DIVD: begin
            sa_in = loi_ff; sb_in = hii_ff; sbv_in = 1'b1;
            wb_in = div_rsp.quo[WG-1:0];
            wa_in = bcw_pkg::ONE_Q16 - div_rsp.quo[WG-1:0];
            state_in = S_SEL;
         end
         S2_RDI: state_in = S2_LDI;
         S2_LDI: begin
            xi_in = ent_x; yi_in = ent_y;
            ipx_in = {px_ff[15], px_ff} - {ent_x[15], ent_x};
            ipy_in = {py_ff[15], py_ff} - {ent_y[15], ent_y};
            j_in = '0; hv_in = 1'b0;
            state_in = S2_RDJ;
         end
         S2_RDJ: begin
            if (j_ff >= n_w) state_in = S2_FIN;
            else if (j_ff == i_ff) j_in = j_ff + 1'b1;
            else state_in = S2_LDJ;
         end
         S2_LDJ: begin
            ijx_in = {ent_x[15], ent_x} - {xi_ff[15], xi_ff};
            ijy_in = {ent_y[15], ent_y} - {yi_ff[15], yi_ff};
            ph_in = '0;
            state_in = S2_MUL;
         end
         S2_MUL: begin
            prod_in = prod;
            ph_in = ph_ff + 1'b1;
            case (ph_ff)
               3'd0: begin den_in = '0; num_in = '0; end
               3'd1: den_in = DOT_W'(prod_ff);
               3'd2: den_in = den_ff + DOT_W'(prod_ff);
               3'd3: num_in = DOT_W'(prod_ff);
               default: begin
                  num_in = num_ff + DOT_W'(prod_ff);
                  ph_in = '0;
                  state_in = S2_DIV;
               end
            endcase
         end
         S2_DIV: begin
            neg_in = num_ff[DOT_W-1];
            dz_in = (den_ff == '0);
            state_in = S2_UPD;
            if (den_ff != '0) begin
               div_req.start = 1'b1;
               div_req.num = {{(NUM_W-DOT_W-16){1'b0}},
                              num_ff[DOT_W-1] ? DOT_W'(-num_ff) : DOT_W'(num_ff), 16'd0};
               ret_in = S2_UPD;
               state_in = S_DWAIT;
            end
         end
         S2_UPD: begin
            if (!hv_ff || band_val < hi_ff) hi_in = band_val;
            hv_in = 1'b1;
            j_in = j_ff + 1'b1;
            state_in = S2_RDJ;
         end
         S2_FIN: begin
            tot_in = tot_ff + {{(TOT_W-WQ_W){1'b0}}, w_fin};
            i_in = i_ff + 1'b1;
            state_in = ((i_ff + 1'b1) < n_w) ? S2_RDI : S2_CHK;
         end
         S2_CHK: begin
            i_in = '0;
            state_in = (tot_ff == '0) ? SN_RD : NR_RD;
         end
         SN_RD: state_in = SN_LD;
         SN_LD: begin
            ipx_in = {px_ff[15], px_ff} - {ent_x[15], ent_x};
            ipy_in = {py_ff[15], py_ff} - {ent_y[15], ent_y};
            ph_in = '0;
            state_in = SN_MUL;
         end
         SN_MUL: begin
            prod_in = prod;
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 3'd1) den_in = DOT_W'(prod_ff);
            if (ph_ff == 3'd2) begin
               den_in = den_ff + DOT_W'(prod_ff);
               ph_in = '0;
               state_in = SN_CMP;
            end
         end
         SN_CMP: begin
            if (i_ff == '0 || den_ff < bd_ff) begin
               bd_in = den_ff; bi_in = i_ff[IW-1:0];
            end
            i_in = i_ff + 1'b1;
            if ((i_ff + 1'b1) >= n_w) begin
               i_in = '0;
               sa_in = (i_ff == '0 || den_ff < bd_ff) ? i_ff[IW-1:0] : bi_ff;
               sbv_in = 1'b0;
               wa_in = bcw_pkg::ONE_Q16;
               state_in = S_SEL;
            end else begin
               state_in = SN_RD;
            end
         end
         SD_RD: state_in = SD_LD;
         SD_LD: begin
            tot_in = tot_ff + {{(TOT_W-WQ_W){1'b0}}, w_dir};
            i_in = i_ff + 1'b1;
            if ((i_ff + 1'b1) >= n_w) begin
               i_in = '0;
               state_in = NR_RD;
            end else begin
               state_in = SD_RD;
            end
         end
         NR_RD: state_in = NR_LD;
         NR_LD: begin
            if (tot_ff == '0) begin
               res_in = '0;
               ret_in = NR_RD;
               state_in = S_EMIT;
            end else begin
               div_req.start = 1'b1;
               div_req.num = {w_src, 16'd0};
               div_req.den = tot_ff;
               ret_in = NR_DIVD;
               state_in = S_DWAIT;
            end
         end
         NR_DIVD: begin
            res_in = div_rsp.quo[WG-1:0];
            ret_in = NR_RD;
            state_in = S_EMIT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S2_FIN) w_mem[i_ff[IW-1:0]] <= w_fin;
      w_rd <= w_mem[i_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ret_ff <= S_IDLE; mode_ff <= '0; cnt_ff <= '0;
         i_ff <= '0; j_ff <= '0; ph_ff <= '0; hv_ff <= 1'b0; sbv_ff <= 1'b0;
         nc_ff <= 1'b0; lov_ff <= 1'b0; hiv_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in; mode_ff <= mode_in; cnt_ff <= cnt_in;
         i_ff <= i_in; j_ff <= j_in; ph_ff <= ph_in; hv_ff <= hv_in; sbv_ff <= sbv_in;
         nc_ff <= nc_in; lov_ff <= lov_in; hiv_ff <= hiv_in; rv_ff <= rv_in;
      end
      dz_ff <= dz_in;     neg_ff <= neg_in;   px_ff <= px_in;     py_ff <= py_in;
      xi_ff <= xi_in;     yi_ff <= yi_in;     mn_ff <= mn_in;     mx_ff <= mx_in;
      lo_ff <= lo_in;     hi1_ff <= hi1_in;   mni_ff <= mni_in;   mxi_ff <= mxi_in;
      loi_ff <= loi_in;   hii_ff <= hii_in;   sa_ff <= sa_in;     sb_ff <= sb_in;
      bi_ff <= bi_in;     wa_ff <= wa_in;     wb_ff <= wb_in;     res_ff <= res_in;
      ipx_ff <= ipx_in;   ipy_ff <= ipy_in;   ijx_ff <= ijx_in;   ijy_ff <= ijy_in;
      prod_ff <= prod_in; den_ff <= den_in;   num_ff <= num_in;   bd_ff <= bd_in;
      hi_ff <= hi_in;     tot_ff <= tot_in;
      o_idx_ff <= o_idx_in; o_w_ff <= o_w_in; o_last_ff <= o_last_in; o_nc_ff <= o_nc_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_weight_index = o_idx_ff;
   assign rsp_weight       = o_w_ff;
   assign rsp_last         = o_last_ff;
   assign rsp_no_children  = o_nc_ff;

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == bcw_pkg::OP_EVAL) |=> req_stall)
      else $error("evaluate transaction did not start the sequencer");

   a_nc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_children |-> rsp_last && (rsp_weight == '0))
      else $error("empty evaluation result malformed");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weight <= bcw_pkg::ONE_Q16))
      else $error("weight above one");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

endmodule
